// ===== src/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg
// Codes and constants shared by the set-associative tag lookup block.
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 2'd3;

    localparam logic [1:0] POL_RANDOM = 2'd0;
    localparam logic [1:0] POL_LRU    = 2'd1;
    localparam logic [1:0] POL_FIFO   = 2'd2;

    localparam logic [1:0] KIND_HIT  = 2'd0;
    localparam logic [1:0] KIND_COMP = 2'd1;
    localparam logic [1:0] KIND_CAP  = 2'd2;

    localparam logic [15:0] LFSR_MASK = 16'hB400;
    localparam logic [15:0] LFSR_SEED = 16'h0001;

endpackage

// ===== src/set_assoc_cache_tag_lookup.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup
// Tag lookup for a set-associative cache with random, LRU or FIFO victims.
// ----------------------------------------------------------------------------
// sequence: set modulo, valid-row read, then a read and a compare per way scanned
// (up to and including the hit way on a hit, every way in use on a miss), a remainder
// for a random victim, then the update and o_valid; the set modulo is a reciprocal
// multiply, the victim modulo a 1-bit-per-cycle remainder unit, the ways read one by one
// a new word is accepted only while busy is low; busy is high until the result strobes
// reset: synchronous active low; afterwards a valid-bit clearing pass over all SETS
// rows keeps busy high; the result strobe cannot be stalled
module set_assoc_cache_tag_lookup #(
    parameter int SETS = 256,
    parameter int WAYS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [31:0]                       i_address,
    input  logic                              i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_valid,
    output logic                              o_hit,
    output logic [1:0]                        o_miss_kind,
    output logic [7:0]                        o_set_index,
    output logic [1:0]                        o_way_used
);

    localparam int SW  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AW  = (SETS * WAYS > 1) ? $clog2(SETS * WAYS) : 1;
    localparam int DVW = 4;

    // reciprocal of SETS, exact for any 15-bit set index
    localparam int          RL = (SETS > 1) ? $clog2(SETS) : 0;
    localparam int          RK = 15 + RL;
    localparam logic [31:0] RM = 32'(((64'd1 << RK) + 64'(SETS) - 64'd1) / 64'(SETS));

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_SDIV = 4'd2;
    localparam logic [3:0] S_VRQ  = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_CMP  = 4'd5;
    localparam logic [3:0] S_VDIV = 4'd6;
    localparam logic [3:0] S_WR   = 4'd7;

    // config
    logic [4:0]  r_offset_bits;
    logic [3:0]  r_index_bits;
    logic [2:0]  r_ways_in_use;
    logic [1:0]  r_policy;

    logic [3:0]  r_state;
    logic [SW-1:0] r_clr_cnt;
    logic [31:0] r_tag;
    logic [2:0]  r_nways;
    logic [SW-1:0] r_set;
    logic [WW-1:0] r_w;
    logic [WAYS-1:0] r_vrow;
    logic [WW-1:0] r_best_w;
    logic [31:0] r_best_stamp;
    logic [WW-1:0] r_way;
    logic        r_hit_f;
    logic [1:0]  r_kind;
    logic [31:0] r_time;
    logic [31:0] r_fill;
    logic [15:0] r_lfsr;

    // set modulo
    logic [14:0] r_quot;
    logic [31:0] quot_full;
    logic [15:0] set_rem;

    // victim remainder unit
    logic [15:0]    r_div_num;
    logic [DVW-1:0] r_div_rem;
    logic [DVW-1:0] r_div_den;
    logic [3:0]     r_div_cnt;
    logic [DVW:0]   div_t;
    logic [DVW-1:0] n_div_rem;

    // memories
    logic [31:0]     tag_mem  [SETS*WAYS];
    logic [31:0]     use_mem  [SETS*WAYS];
    logic [31:0]     fill_mem [SETS*WAYS];
    logic [WAYS-1:0] vld_mem  [SETS];
    logic [31:0]     r_tag_rd;
    logic [31:0]     r_use_rd;
    logic [31:0]     r_fill_rd;

    logic          r_valid;
    logic [AW-1:0] mem_addr;
    logic [AW-1:0] wr_addr;
    logic [5:0]    shift_sum;
    logic [15:0]   idx_val;
    logic [2:0]    nways_val;
    logic [31:0]   stamp_cur;
    logic          last_way;
    logic          free_found;
    logic [WW-1:0] free_w;
    logic [15:0]   n_lfsr;
    logic [WW-1:0] best_w_now;
    logic          hit_now;
    logic          accept;

    assign accept   = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign mem_addr = AW'(32'(r_set) * 32'(WAYS) + 32'(r_w));
    assign wr_addr  = AW'(32'(r_set) * 32'(WAYS) + 32'(r_way));

    assign shift_sum = 6'(r_offset_bits) + 6'(r_index_bits);
    assign idx_val   = 16'((i_address >> r_offset_bits) &
                           ((32'd1 << r_index_bits) - 32'd1));

    assign quot_full = 32'(r_div_num[14:0]) * RM;
    assign set_rem   = 16'(32'(r_div_num) - 32'(r_quot) * 32'(SETS));

    always_comb begin
        if (r_ways_in_use == 3'd0) begin
            nways_val = 3'd1;
        end else if (32'(r_ways_in_use) > WAYS) begin
            nways_val = 3'(WAYS);
        end else begin
            nways_val = r_ways_in_use;
        end
    end

    assign div_t     = {r_div_rem, r_div_num[15]};
    assign n_div_rem = (div_t >= {1'b0, r_div_den}) ? DVW'(div_t - {1'b0, r_div_den})
                                                    : DVW'(div_t);

    assign stamp_cur = (r_policy == sacl_pkg::POL_FIFO) ? r_fill_rd : r_use_rd;
    assign last_way  = (int'(r_w) + 1 == int'(r_nways));
    assign hit_now   = r_vrow[r_w] && (r_tag_rd == r_tag);
    assign best_w_now = (r_w == '0 || stamp_cur < r_best_stamp) ? r_w : r_best_w;
    assign n_lfsr    = r_lfsr[0] ? ((r_lfsr >> 1) ^ sacl_pkg::LFSR_MASK) : (r_lfsr >> 1);

    // lowest invalid way in use
    always_comb begin
        free_found = 1'b0;
        free_w     = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (!free_found && i < int'(r_nways) && !r_vrow[i]) begin
                free_found = 1'b1;
                free_w     = WW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= 5'd0;
            r_index_bits  <= 4'd8;
            r_ways_in_use <= 3'd4;
            r_policy      <= sacl_pkg::POL_LRU;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sacl_pkg::CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                sacl_pkg::CFG_INDEX_BITS:  r_index_bits  <= i_cfg_data[3:0];
                sacl_pkg::CFG_WAYS_IN_USE: r_ways_in_use <= i_cfg_data[2:0];
                sacl_pkg::CFG_POLICY:      r_policy      <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_cnt <= '0;
            r_time    <= '0;
            r_fill    <= '0;
            r_lfsr    <= sacl_pkg::LFSR_SEED;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr_cnt <= SW'(32'(r_clr_cnt) + 1);
                    if (32'(r_clr_cnt) == SETS - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_tag     <= (shift_sum >= 6'd32) ? 32'd0 : (i_address >> shift_sum);
                        r_nways   <= nways_val;
                        r_div_num <= idx_val;
                        r_state   <= S_SDIV;
                    end
                end
                S_SDIV: begin
                    r_quot  <= 15'(quot_full >> RK);
                    r_state <= S_VRQ;
                end
                S_VRQ: begin
                    r_set   <= set_rem[SW-1:0];
                    r_w     <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_best_w     <= best_w_now;
                    r_best_stamp <= (best_w_now == r_w) ? stamp_cur : r_best_stamp;
                    if (hit_now) begin
                        r_hit_f <= 1'b1;
                        r_kind  <= sacl_pkg::KIND_HIT;
                        r_way   <= r_w;
                        r_state <= S_WR;
                    end else if (last_way) begin
                        r_hit_f <= 1'b0;
                        if (free_found) begin
                            r_kind  <= sacl_pkg::KIND_COMP;
                            r_way   <= free_w;
                            r_state <= S_WR;
                        end else if (r_policy == sacl_pkg::POL_RANDOM) begin
                            r_kind    <= sacl_pkg::KIND_CAP;
                            r_lfsr    <= n_lfsr;
                            r_div_num <= n_lfsr;
                            r_div_rem <= '0;
                            r_div_den <= DVW'(r_nways);
                            r_div_cnt <= 4'd0;
                            r_state   <= S_VDIV;
                        end else begin
                            r_kind  <= sacl_pkg::KIND_CAP;
                            r_way   <= best_w_now;
                            r_state <= S_WR;
                        end
                    end else begin
                        r_w     <= r_w + WW'(1);
                        r_state <= S_RD;
                    end
                end
                S_VDIV: begin
                    r_div_rem <= n_div_rem;
                    r_div_num <= r_div_num << 1;
                    r_div_cnt <= r_div_cnt + 4'd1;
                    if (r_div_cnt == 4'd15) begin
                        r_way   <= n_div_rem[WW-1:0];
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_time  <= r_time + 32'd1;
                    if (!r_hit_f) begin
                        r_fill <= r_fill + 32'd1;
                    end
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // valid rows, one word per set
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) begin
            vld_mem[r_clr_cnt] <= '0;
        end else if (r_state == S_WR && !r_hit_f) begin
            vld_mem[r_set] <= r_vrow | (WAYS'(1) << r_way);
        end
        if (r_state == S_VRQ) begin
            r_vrow <= vld_mem[set_rem[SW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WR && !r_hit_f) begin
            tag_mem[wr_addr] <= r_tag;
        end
        r_tag_rd <= tag_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            use_mem[wr_addr] <= r_time;
        end
        r_use_rd <= use_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WR && !r_hit_f) begin
            fill_mem[wr_addr] <= r_fill;
        end
        r_fill_rd <= fill_mem[mem_addr];
    end

    assign o_valid     = r_valid;
    assign o_hit       = r_hit_f;
    assign o_miss_kind = r_kind;
    assign o_set_index = 8'(r_set);
    assign o_way_used  = 2'(r_way);

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_hit_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit == (o_miss_kind == sacl_pkg::KIND_HIT)))
        else $error("hit flag disagrees with miss kind");

endmodule
